// ===== hw/rtl/jls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jls_pkg
// Shared types and constants of the Jacobi Laplace sweep block.
// ----------------------------------------------------------------------------
package jls_pkg;

  // Smallest grid side the block works on; smaller settings act as this.
  localparam int unsigned MinGrid = 3;

  // Width of the row and column coordinates on the result channel.
  localparam int unsigned CenterBits = 12;

  // Width of the grid size register.
  localparam int unsigned GridSizeBits = 13;

  // Per-item control that travels from the sequencer to the stencil datapath.
  typedef struct packed {
    logic advance;    // item leaves the read stage this cycle
    logic row_start;  // item sits in column 0
    logic row_end;    // item sits in the last column
    logic interior;   // item closes an interior point
    logic last;       // item closes the final interior point of the sweep
  } ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/jls_row_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jls_row_mem
// One-row store: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module jls_row_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/jls_stencil.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jls_stencil
// Middle-row window, four-neighbour average and running maximum change.
// ----------------------------------------------------------------------------
module jls_stencil #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire jls_pkg::ctrl_t         ctrl_i,
  input  wire logic                   clear_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [SAMPLE_BITS-1:0] up_data_i,
  input  wire logic [SAMPLE_BITS-1:0] mid_data_i,
  output      logic [SAMPLE_BITS-1:0] up_wdata_o,
  output      logic [SAMPLE_BITS-1:0] new_value_o,
  output      logic [SAMPLE_BITS-1:0] peak_delta_o
);

  localparam int unsigned SumBits = SAMPLE_BITS + 2;

  logic [SAMPLE_BITS-1:0] w1_q, w2_q;
  logic [SAMPLE_BITS-1:0] w0_d, w1_d, w2_d;
  logic [SAMPLE_BITS-1:0] pre_q;
  logic [SAMPLE_BITS-1:0] max_q, max_d;
  logic [SumBits-1:0]     sum;
  logic [SAMPLE_BITS-1:0] diff;

  // Column 0 takes the word fetched by the previous item (address 0).
  always_comb begin
    w0_d = ctrl_i.row_start ? '0 : w1_q;
    w1_d = ctrl_i.row_start ? pre_q : w2_q;
    w2_d = ctrl_i.row_end ? '0 : mid_data_i;
  end

  always_comb begin
    sum = SumBits'(up_data_i) + SumBits'(w0_d) + SumBits'(w2_d) + SumBits'(sample_i);
    new_value_o = sum[SumBits-1:2];
    diff = (new_value_o > w1_d) ? new_value_o - w1_d : w1_d - new_value_o;
    max_d = (diff > max_q) ? diff : max_q;
  end

  assign up_wdata_o   = w1_d;
  assign peak_delta_o = max_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q <= '0;
      w2_q <= '0;
    end else if (ctrl_i.advance) begin
      w1_q <= w1_d;
      w2_q <= w2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      pre_q <= mid_data_i;
    end
  end

  // Drop the maximum after the final point and on a new grid size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else if (clear_i) begin
      max_q <= '0;
    end else if (ctrl_i.advance && ctrl_i.interior) begin
      max_q <= ctrl_i.last ? '0 : max_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/jacobi_laplace_sweep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_laplace_sweep
// One Jacobi sweep of a square grid with the 5-point Laplace stencil.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ------------------------------------------
//  cfg       cfg_valid_i/cfg_ready_o cfg_grid_size_i (side length, 3..MAX_GRID)
//  in        in_valid_i/in_ready_o   sample_i (old value, unsigned Q1.15)
//  out       out_valid_o/out_ready_i new_value_o, center_row_o, center_column_o,
//                                    peak_delta_o, last_o
//
//  Throughput is one sample per cycle while results are not stalled. The row
//  stores are read on the edge that transfers a sample, and the output register
//  loads when that sample leaves the read stage, which a stall can delay.
//  Reset clears counters, window and maximum; the row stores need no clearing.
//  A stalled result holds the output register; the read stage takes at most one
//  more sample, then in_ready_o drops until the result transfers.
//
// ----------------------------------------------------------------------------
module jacobi_laplace_sweep #(
  parameter int unsigned MAX_GRID    = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [jls_pkg::GridSizeBits-1:0]    cfg_grid_size_i,
  // samples
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]              sample_i,
  // results
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic [SAMPLE_BITS-1:0]              new_value_o,
  output      logic [jls_pkg::CenterBits-1:0]      center_row_o,
  output      logic [jls_pkg::CenterBits-1:0]      center_column_o,
  output      logic [SAMPLE_BITS-1:0]              peak_delta_o,
  output      logic                                last_o
);

  localparam int unsigned CW = $clog2(MAX_GRID);       // coordinate width
  localparam int unsigned NW = $clog2(MAX_GRID + 1);   // grid side width
  localparam int unsigned CB = jls_pkg::CenterBits;

  // --------------------------------------------------------------------------
  // Grid side register, clamped on write
  // --------------------------------------------------------------------------
  logic [NW-1:0] n_q, n_d;
  logic [31:0]   grid32;
  logic          cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign grid32      = 32'(cfg_grid_size_i);

  always_comb begin
    if (grid32 < jls_pkg::MinGrid) begin
      n_d = NW'(jls_pkg::MinGrid);
    end else if (grid32 > MAX_GRID) begin
      n_d = NW'(MAX_GRID);
    end else begin
      n_d = NW'(grid32);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= NW'(MAX_GRID);
    end else if (cfg_fire) begin
      n_q <= n_d;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and position counters
  // --------------------------------------------------------------------------
  logic          s1_valid_q;
  logic          s1_adv;
  logic          in_fire;
  logic [CW-1:0] col_q, row_q;
  logic          col_wrap, row_wrap;
  logic [CW-1:0] mid_raddr;

  assign s1_adv     = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  assign col_wrap = (NW'(col_q) == n_q - 1'b1);
  assign row_wrap = (NW'(row_q) == n_q - 1'b1);

  // Fetch the right-hand middle neighbour; at the row end fetch column 0,
  // which the first sample of the next row needs as its center.
  assign mid_raddr = col_wrap ? '0 : col_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_fire) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Read stage: sample and position wait here for the store read data
  // --------------------------------------------------------------------------
  logic [CW-1:0]          s1_col_q, s1_row_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q    <= col_q;
      s1_row_q    <= row_q;
      s1_sample_q <= sample_i;
    end
  end

  jls_pkg::ctrl_t ctrl;
  logic [NW-1:0]  s1_col_n, s1_row_n;

  assign s1_col_n = NW'(s1_col_q);
  assign s1_row_n = NW'(s1_row_q);

  always_comb begin
    ctrl.advance   = s1_adv;
    ctrl.row_start = (s1_col_q == '0);
    ctrl.row_end   = (s1_col_n == n_q - 1'b1);
    ctrl.interior  = (s1_row_n >= NW'(2)) && (s1_col_n >= NW'(1))
                     && (s1_col_n <= n_q - NW'(2));
    ctrl.last      = (s1_row_n == n_q - 1'b1) && (s1_col_n == n_q - NW'(2));
  end

  // --------------------------------------------------------------------------
  // Row stores: reads issue on the transfer, writes when the item advances.
  // Consecutive items never touch the same column, so no forwarding is needed.
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] up_rdata, mid_rdata, up_wdata;

  jls_row_mem #(
    .DEPTH (MAX_GRID),
    .WIDTH (SAMPLE_BITS)
  ) u_upper_mem (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (up_wdata),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (up_rdata)
  );

  jls_row_mem #(
    .DEPTH (MAX_GRID),
    .WIDTH (SAMPLE_BITS)
  ) u_middle_mem (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (s1_sample_q),
    .re_i    (in_fire),
    .raddr_i (mid_raddr),
    .rdata_o (mid_rdata)
  );

  // --------------------------------------------------------------------------
  // Stencil datapath
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] nv, max_err;

  jls_stencil #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_stencil (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .clear_i      (cfg_fire),
    .sample_i     (s1_sample_q),
    .up_data_i    (up_rdata),
    .mid_data_i   (mid_rdata),
    .up_wdata_o   (up_wdata),
    .new_value_o  (nv),
    .peak_delta_o (max_err)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic          out_valid_q;
  logic [CW-1:0] row_m1;

  assign row_m1      = s1_row_q - 1'b1;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && ctrl.interior) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && ctrl.interior) begin
      new_value_o     <= nv;
      center_row_o    <= CB'(row_m1);
      center_column_o <= CB'(s1_col_q);
      peak_delta_o    <= max_err;
      last_o          <= ctrl.last;
    end
  end

endmodule
`default_nettype wire
